// File: hw/rtl/assert_macros.svh
// Assertion macros for the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CPM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define CPM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

// File: hw/rtl/cpm_pkg.sv
// Types and constants for the charge pilot monitor.
// No dependencies.
package cpm_pkg;
    localparam int unsigned IN_W  = 104;
    localparam int unsigned OUT_W = 96;
    localparam logic [55:0] E_MAX = 56'hFF_FFFF_FFFF_FFFF;
    localparam logic [17:0] MA_MAX = 18'h3FFFF;
    localparam logic [2:0] ST_A = 3'd0, ST_B = 3'd1, ST_C = 3'd2, ST_D = 3'd3,
                           ST_E = 3'd4, ST_F = 3'd5, ST_UNK = 3'd6;
    localparam logic [1:0] EV_CHANGE = 2'd0, EV_START = 2'd1, EV_END = 2'd2;
    localparam logic [2:0] CFG_PNUM = 3'd0, CFG_PDEN = 3'd1, CFG_PBIAS = 3'd2,
                           CFG_CNUM = 3'd3, CFG_CDEN = 3'd4, CFG_VOLTS = 3'd5,
                           CFG_TOL = 3'd6;
    localparam logic [3:0] OP_PDIV = 4'd0, OP_CDIV = 4'd1, OP_DDIV = 4'd2,
                           OP_MUL1 = 4'd3, OP_MUL2 = 4'd4, OP_CHK = 4'd5,
                           OP_ACC = 4'd6, OP_FIN = 4'd7;
    typedef struct packed {
        logic       load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       mul_start;
        logic       mul_sel;
        logic       accum;
        logic       finish;
    } t_cmd;
    typedef struct packed {
        logic div_busy;
        logic mul_busy;
    } t_sts;
endpackage

// File: hw/rtl/charge_pilot_monitor.sv
// Top level of the charge pilot monitor: stream ports, controller, datapath.
// Depends on cpm_pkg, cpm_ctrl and cpm_datapath.
// An edge beat (kind 1) is absorbed on acceptance and gives no result. A poll
// beat holds the block busy from its accepting edge: three 46-step divides on
// one shared divider (pilot scale, current scale, duty), each with an issue and
// a handoff step, then two 40-step passes of the shift-add multiplier (power,
// energy step), then one accumulate and one finish step. The result lands in
// the output register; the next beat is taken as soon as the sequence is done,
// and finish holds while the previous result has not yet been taken.
module charge_pilot_monitor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: pilot_reading_mv[11:0], current_reading_mv[23:12], proximity[24],
    //        time_ms[64:25], edge_level[65], edge_time_us[97:66], zero pad
    input  logic [103:0] s_axis_tdata,
    // tuser: kind
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: send[0], pilot_class[3:1], proximity_out[4], duty_centipct[18:5],
    //        current_ma[36:19], energy_uj[92:37], has_session[93],
    //        event_kind[95:94]
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import cpm_pkg::*;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy, w_acc, r_ovalid, w_out_full;
    assign s_axis_tready = !w_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_out_full = r_ovalid && !m_axis_tready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_cmd.finish) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end
    assign m_axis_tvalid = r_ovalid;
    cpm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_acc && !s_axis_tuser),
        .i_out_full(w_out_full), .i_sts(w_sts), .o_cmd(w_cmd), .o_busy(w_busy)
    );
    cpm_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_edge_we(w_acc && s_axis_tuser), .i_edge_level(s_axis_tdata[65]),
        .i_edge_time_us(s_axis_tdata[97:66]), .i_pilot_rd(s_axis_tdata[11:0]),
        .i_cur_rd(s_axis_tdata[23:12]), .i_prox(s_axis_tdata[24]),
        .i_time_ms(s_axis_tdata[64:25]), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_cmd(w_cmd), .o_sts(w_sts), .o_result(m_axis_tdata)
    );
endmodule

// File: hw/rtl/cpm_ctrl.sv
// Sequencer for one poll: three divides, two multiplies, accumulate, finish.
// Depends on cpm_pkg.
module cpm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_out_full,
    input  cpm_pkg::t_sts i_sts,
    output cpm_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import cpm_pkg::*;
    logic       r_busy, n_busy;
    logic [3:0] r_op, n_op;
    logic       r_go, n_go;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op <= OP_PDIV;
            r_go <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_op <= n_op;
            r_go <= n_go;
        end
    end
    always_comb begin
        n_busy = r_busy;
        n_op = r_op;
        n_go = 1'b0;
        o_cmd = '0;
        o_cmd.load = i_start && !r_busy;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_op = OP_PDIV;
                n_go = 1'b1;
            end
        end else if (r_go) begin
            unique case (r_op)
                OP_PDIV, OP_CDIV, OP_DDIV: begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel = r_op[1:0];
                end
                OP_MUL1, OP_MUL2: begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel = (r_op == OP_MUL2);
                end
                default: ;
            endcase
        end else if (!i_sts.div_busy && !i_sts.mul_busy) begin
            unique case (r_op)
                OP_PDIV, OP_CDIV, OP_DDIV, OP_MUL1: begin
                    n_op = r_op + 4'd1;
                    n_go = 1'b1;
                end
                OP_MUL2: n_op = OP_ACC;
                OP_ACC: begin
                    o_cmd.accum = 1'b1;
                    n_op = OP_FIN;
                end
                OP_FIN: begin
                    // hold while the previous beat still waits at the output
                    if (!i_out_full) begin
                        o_cmd.finish = 1'b1;
                        n_busy = 1'b0;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end
    end
    assign o_busy = r_busy;
endmodule

// File: hw/rtl/cpm_datapath.sv
// Datapath: timing state, shared restoring divider, shift-add multiplier,
// classification, energy and session tracking. Depends on cpm_pkg.
module cpm_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_edge_we,
    input  logic          i_edge_level,
    input  logic [31:0]   i_edge_time_us,
    input  logic [11:0]   i_pilot_rd,
    input  logic [11:0]   i_cur_rd,
    input  logic          i_prox,
    input  logic [39:0]   i_time_ms,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  cpm_pkg::t_cmd i_cmd,
    output cpm_pkg::t_sts o_sts,
    output logic [95:0]   o_result
);
    import cpm_pkg::*;
    logic [15:0] r_pnum, r_pden, r_pbias, r_cnum, r_cden;
    logic [9:0]  r_volts;
    logic [11:0] r_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pnum <= 16'd1; r_pden <= 16'd1; r_pbias <= '0;
            r_cnum <= 16'd1; r_cden <= 16'd1; r_volts <= 10'd240; r_tol <= 12'd500;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PNUM:  r_pnum <= i_cfg_data;
                CFG_PDEN:  r_pden <= i_cfg_data;
                CFG_PBIAS: r_pbias <= i_cfg_data;
                CFG_CNUM:  r_cnum <= i_cfg_data;
                CFG_CDEN:  r_cden <= i_cfg_data;
                CFG_VOLTS: r_volts <= i_cfg_data[9:0];
                CFG_TOL:   r_tol <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    logic        r_rise_seen;
    logic [31:0] r_last_rise, r_high, r_period;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_seen <= 1'b0; r_last_rise <= '0; r_high <= '0; r_period <= '0;
        end else if (i_edge_we) begin
            if (i_edge_level) begin
                if (r_rise_seen) r_period <= i_edge_time_us - r_last_rise;
                r_last_rise <= i_edge_time_us;
                r_rise_seen <= 1'b1;
            end else if (r_rise_seen) begin
                r_high <= i_edge_time_us - r_last_rise;
            end
        end
    end

    logic [11:0] r_prd, r_crd;
    logic        r_prox;
    logic [39:0] r_tms;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prd <= i_pilot_rd; r_crd <= i_cur_rd; r_prox <= i_prox; r_tms <= i_time_ms;
        end
    end

    // restoring divider, 46-bit dividend, one quotient bit per cycle
    logic [45:0] r_dq;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_dcnt;
    logic        r_dbusy;
    logic [1:0]  r_dsel;
    logic [45:0] w_dvd;
    logic [31:0] w_den;
    logic [33:0] w_trial;
    logic [27:0] w_pprod, w_cprod;
    logic [45:0] w_hx;
    assign w_pprod = {16'd0, r_prd} * {12'd0, r_pnum};
    assign w_cprod = {16'd0, r_crd} * {12'd0, r_cnum};
    assign w_hx = {14'd0, r_high} * 46'd10000;
    always_comb begin
        unique case (i_cmd.div_sel)
            OP_PDIV[1:0]: begin
                w_dvd = {18'd0, w_pprod};
                w_den = {16'd0, (r_pden == 16'd0) ? 16'd1 : r_pden};
            end
            OP_CDIV[1:0]: begin
                w_dvd = {18'd0, w_cprod};
                w_den = {16'd0, (r_cden == 16'd0) ? 16'd1 : r_cden};
            end
            default: begin
                w_dvd = w_hx;
                w_den = (r_period == 32'd0) ? 32'd1 : r_period;
            end
        endcase
    end
    assign w_trial = {r_rem, r_dq[45]} - {2'd0, r_den};
    logic [27:0] r_pq;
    logic [17:0] r_ma;
    logic [13:0] r_duty;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0; r_dcnt <= '0; r_dsel <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1; r_dcnt <= 6'd46; r_dsel <= i_cmd.div_sel;
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt - 6'd1;
            if (r_dcnt == 6'd1) r_dbusy <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq <= w_dvd; r_rem <= '0; r_den <= w_den;
        end else if (r_dbusy) begin
            if (!w_trial[33]) begin
                r_rem <= w_trial[32:0];
                r_dq <= {r_dq[44:0], 1'b1};
            end else begin
                r_rem <= {r_rem[31:0], r_dq[45]};
                r_dq <= {r_dq[44:0], 1'b0};
            end
            if (r_dcnt == 6'd1) begin
                unique case (r_dsel)
                    OP_PDIV[1:0]: r_pq <= w_trial[33] ? {r_dq[26:0], 1'b0}
                                                      : {r_dq[26:0], 1'b1};
                    OP_CDIV[1:0]: r_ma <= (r_dq[44:17] != '0) ? MA_MAX
                                        : (w_trial[33] ? {r_dq[16:0], 1'b0}
                                                       : {r_dq[16:0], 1'b1});
                    default: r_duty <= w_trial[33] ? {r_dq[12:0], 1'b0}
                                                   : {r_dq[12:0], 1'b1};
                endcase
            end
        end
    end

    // shift-add multiplier: 56-bit product, 40 steps per pass
    logic [55:0] r_macc, r_mcand;
    logic [39:0] r_mier;
    logic [5:0]  r_mcnt;
    logic        r_mbusy;
    logic        r_movf;
    logic [27:0] r_pwr;
    logic [39:0] r_last_t;
    logic [39:0] w_dt;
    logic        w_tadv;
    logic [56:0] w_madd;
    assign w_tadv = r_tms > r_last_t;
    assign w_dt = r_tms - r_last_t;
    assign w_madd = {1'b0, r_macc} + {1'b0, r_mcand};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0; r_mcnt <= '0;
        end else if (i_cmd.mul_start) begin
            r_mbusy <= 1'b1; r_mcnt <= 6'd40;
        end else if (r_mbusy) begin
            r_mcnt <= r_mcnt - 6'd1;
            if (r_mcnt == 6'd1) r_mbusy <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_macc <= '0; r_movf <= 1'b0;
            if (!i_cmd.mul_sel) begin
                r_mcand <= {38'd0, r_ma}; r_mier <= {30'd0, r_volts};
            end else begin
                r_mcand <= {28'd0, r_pwr}; r_mier <= w_dt;
            end
        end else if (r_mbusy) begin
            if (r_mier[0]) r_macc <= w_madd[55:0];
            r_movf <= r_movf || (r_mier[0] && w_madd[56])
                      || (r_mcand[55] && (r_mier[39:1] != '0));
            r_mcand <= {r_mcand[54:0], 1'b0};
            r_mier <= {1'b0, r_mier[39:1]};
        end
    end
    logic r_mul_phase;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mul_phase <= 1'b0;
        else if (i_cmd.mul_start) r_mul_phase <= i_cmd.mul_sel;
    end
    logic r_mbusy_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mbusy_d <= 1'b0;
        else r_mbusy_d <= r_mbusy;
    end
    always_ff @(posedge i_clk) begin
        if (r_mbusy_d && !r_mbusy && !r_mul_phase) r_pwr <= r_macc[27:0];
    end

    // classification and session state
    logic signed [29:0] w_pmv;
    logic signed [29:0] w_tol;
    logic [2:0]  w_st;
    assign w_pmv = $signed({2'b0, r_pq}) - $signed({14'd0, r_pbias});
    assign w_tol = $signed({18'd0, r_tol});
    always_comb begin
        priority if (w_pmv >= 30'sd12000 - w_tol) w_st = ST_A;
        else if (w_pmv >= 30'sd9000 - w_tol) w_st = ST_B;
        else if (w_pmv >= 30'sd6000 - w_tol) w_st = ST_C;
        else if (w_pmv >= 30'sd3000 - w_tol) w_st = ST_D;
        else if (w_pmv >= -30'sd1000 - w_tol) w_st = ST_E;
        else w_st = ST_F;
    end
    logic        w_dvalid;
    assign w_dvalid = (r_period != '0) && (r_high != '0) && (r_high <= r_period);

    logic [2:0]  r_prev_st;
    logic        r_prev_prox, r_time_seen, r_in_sess, r_sess_seen;
    logic [55:0] r_energy;
    logic [56:0] w_esum;
    logic [55:0] w_inc;
    assign w_inc = r_movf ? E_MAX : r_macc;
    assign w_esum = {1'b0, r_energy} + {1'b0, w_inc};
    logic        w_chg;
    assign w_chg = (w_st != r_prev_st) || (r_prox != r_prev_prox);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_st <= ST_UNK; r_prev_prox <= 1'b0; r_time_seen <= 1'b0;
            r_last_t <= '0; r_in_sess <= 1'b0; r_sess_seen <= 1'b0; r_energy <= '0;
        end else begin
            if (i_cmd.accum) begin
                if (r_time_seen && (w_st == ST_C || w_st == ST_D) && w_tadv)
                    r_energy <= w_esum[56] ? E_MAX : w_esum[55:0];
            end
            if (i_cmd.finish) begin
                r_time_seen <= 1'b1;
                r_last_t <= r_tms;
                r_prev_st <= w_st;
                r_prev_prox <= r_prox;
                o_result <= {(w_chg && r_prev_st == ST_A && w_st == ST_B) ? EV_START :
                             (w_chg && r_in_sess && w_st == ST_A) ? EV_END : EV_CHANGE,
                             r_sess_seen, r_energy, r_ma,
                             w_dvalid ? r_duty : 14'd0, r_prox, w_st, w_chg};
                if (w_chg) begin
                    if (r_prev_st == ST_A && w_st == ST_B) begin
                        r_sess_seen <= 1'b1; r_in_sess <= 1'b1; r_energy <= '0;
                    end else if (r_in_sess && w_st == ST_A) begin
                        r_in_sess <= 1'b0;
                    end
                end
            end
        end
    end
    assign o_sts.div_busy = r_dbusy;
    assign o_sts.mul_busy = r_mbusy;
endmodule

// File: hw/rtl/cpm_checker.sv
// Port-level checker for the charge pilot monitor, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module cpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    logic w_poll_acc, w_stall;
    assign w_poll_acc = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
    assign w_stall = m_axis_tvalid && !m_axis_tready;
    `CPM_ASSERT_NXT(a_poll_busy, i_clk, i_rst_n, w_poll_acc, !s_axis_tready)
    `CPM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `CPM_ASSERT_IMP(a_state_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[3:1] <= 3'd5)
    `CPM_ASSERT_IMP(a_ev_send, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[95:94] != 2'd0, m_axis_tdata[0])
endmodule
bind charge_pilot_monitor cpm_checker u_cpm_checker (.*);

// File: test/tb.sv
// Self-checking bench for charge_pilot_monitor: random pilot edges and polls in, status out.
// Depends on cpm_pkg and the charge_pilot_monitor RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cpm_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [11:0] pilot_rd;
        logic [11:0] cur_rd;
        logic        prox;
        logic [39:0] t_ms;
        logic        level;
        logic [31:0] t_us;
    } t_beat;

    // packed from the top bit down, matching the result tdata layout
    typedef struct packed {
        logic [1:0]  ev;
        logic        has;
        logic [55:0] energy;
        logic [17:0] ma;
        logic [13:0] duty;
        logic        prox;
        logic [2:0]  pstate;
        logic        send;
    } t_status;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [95:0]  m_axis_tdata;
    logic         i_cfg_we = 0;
    logic [2:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;

    charge_pilot_monitor uut (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // predictor state
    logic [15:0] p_num, p_den, p_bias, c_num, c_den;
    logic [9:0]  volts;
    logic [11:0] tol;
    logic [2:0]  prev_st;
    logic        prev_prox, rise_seen, time_seen, in_sess, sess_seen;
    logic [31:0] last_rise, high_us, period;
    logic [55:0] energy;
    logic [39:0] last_ms;

    t_beat   pending_beats[$];
    t_status expected_status[$];
    int      errors = 0;
    int      gap_left = 0;
    int      stall_left = 0;
    logic    in_taken = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    task automatic reset_predictor();
        p_num = 1; p_den = 1; p_bias = 0; c_num = 1; c_den = 1;
        volts = 240; tol = 500;
        prev_st = ST_UNK; prev_prox = 0; rise_seen = 0; time_seen = 0;
        in_sess = 0; sess_seen = 0;
        last_rise = 0; high_us = 0; period = 0; energy = 0; last_ms = 0;
    endtask

    function automatic logic [2:0] classify_pilot(longint mv);
        longint t;
        t = tol;
        if (mv >= 12000 - t) return ST_A;
        if (mv >= 9000 - t) return ST_B;
        if (mv >= 6000 - t) return ST_C;
        if (mv >= 3000 - t) return ST_D;
        if (mv >= -1000 - t) return ST_E;
        return ST_F;
    endfunction

    task automatic predict_status(t_beat b);
        t_status s;
        longint unsigned mv_u, ma, p, inc, dt, em;
        longint mv;
        logic [2:0] st;
        em = E_MAX;
        if (b.kind) begin
            if (b.level) begin
                if (rise_seen) period = b.t_us - last_rise;
                last_rise = b.t_us;
                rise_seen = 1;
            end else if (rise_seen) begin
                high_us = b.t_us - last_rise;
            end
            return;
        end
        mv_u = (64'(b.pilot_rd) * p_num) / (p_den == 0 ? 64'd1 : 64'(p_den));
        mv = longint'(mv_u) - longint'(p_bias);
        st = classify_pilot(mv);
        ma = (64'(b.cur_rd) * c_num) / (c_den == 0 ? 64'd1 : 64'(c_den));
        if (ma > MA_MAX) ma = MA_MAX;
        s = '0;
        if (period != 0 && high_us != 0 && high_us <= period)
            s.duty = 14'((64'(high_us) * 10000) / period);
        if (time_seen && (st == ST_C || st == ST_D) && b.t_ms > last_ms) begin
            dt = b.t_ms - last_ms;
            p = ma * volts;
            if (p != 0 && dt > em / p) inc = em;
            else inc = p * dt;
            if (inc > em - energy) energy = E_MAX;
            else energy = energy + 56'(inc);
        end
        time_seen = 1;
        last_ms = b.t_ms;
        s.energy = energy;
        s.has = sess_seen;
        if (st != prev_st || b.prox != prev_prox) begin
            s.send = 1;
            if (prev_st == ST_A && st == ST_B) begin
                sess_seen = 1; in_sess = 1; energy = 0; s.ev = EV_START;
            end else if (in_sess && st == ST_A) begin
                s.ev = EV_END; in_sess = 0;
            end
        end
        prev_st = st;
        prev_prox = b.prox;
        s.pstate = st;
        s.prox = b.prox;
        s.ma = 18'(ma);
        expected_status.push_back(s);
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;

    // driver
    always @(negedge i_clk) begin
        t_beat b;
        if (i_rst_n) begin
            if (s_axis_tvalid && in_taken) gap_left = gap_len();
            if (!s_axis_tvalid || in_taken) begin
                if (gap_left == 0 && pending_beats.size() > 0) begin
                    b = pending_beats.pop_front();
                    predict_status(b);
                    s_axis_tuser <= b.kind;
                    s_axis_tdata <= {6'd0, b.t_us, b.level, b.t_ms, b.prox, b.cur_rd,
                                     b.pilot_rd};
                    s_axis_tvalid <= 1;
                end else begin
                    if (gap_left > 0) gap_left--;
                    s_axis_tvalid <= 0;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
                if ($urandom_range(0, 9) == 0) stall_left = gap_len();
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_status g, w;
            g = m_axis_tdata;
            if (expected_status.size() == 0) begin
                report_mismatch("result count", 1, 0);
            end else begin
                w = expected_status.pop_front();
                if (g.send != w.send) report_mismatch("send", g.send, w.send);
                if (g.pstate != w.pstate) report_mismatch("pilot_class", g.pstate, w.pstate);
                if (g.prox != w.prox) report_mismatch("proximity", g.prox, w.prox);
                if (g.duty != w.duty) report_mismatch("duty", g.duty, w.duty);
                if (g.ma != w.ma) report_mismatch("current_ma", g.ma, w.ma);
                if (g.energy != w.energy) report_mismatch("energy", g.energy, w.energy);
                if (g.has != w.has) report_mismatch("has_session", g.has, w.has);
                if (g.ev != w.ev) report_mismatch("event_kind", g.ev, w.ev);
            end
        end
    end

    logic [39:0] clock_ms = 0;
    logic [31:0] clock_us = 0;

    function automatic t_beat poll_beat(logic [11:0] prd, logic [11:0] crd, logic px);
        t_beat b;
        b = '0;
        b.pilot_rd = prd;
        b.cur_rd = crd;
        b.prox = px;
        b.level = 1'($urandom_range(0, 1));
        b.t_us = $urandom;
        case ($urandom_range(0, 9))
            0: b.t_ms = 40'({$urandom, $urandom});
            1: b.t_ms = clock_ms - $urandom_range(0, 5);
            default: b.t_ms = clock_ms + $urandom_range(0, 2000);
        endcase
        clock_ms = b.t_ms;
        return b;
    endfunction

    function automatic t_beat edge_beat(logic lvl, logic [31:0] dt);
        t_beat b;
        b = '0;
        b.kind = 1;
        b.level = lvl;
        clock_us = clock_us + dt;
        b.t_us = clock_us;
        b.pilot_rd = 12'($urandom);
        b.cur_rd = 12'($urandom);
        b.prox = 1'($urandom_range(0, 1));
        b.t_ms = 40'({$urandom, $urandom});
        return b;
    endfunction

    // pilot reading for a state
    function automatic logic [11:0] reading_for(int st);
        case (st)
            0: return 12'($urandom_range(3000, 4095));
            1: return 12'($urandom_range(2600, 2999));
            default: return 12'($urandom_range(0, 2500));
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_PNUM:  p_num = val;
            CFG_PDEN:  p_den = val;
            CFG_PBIAS: p_bias = val;
            CFG_CNUM:  c_num = val;
            CFG_CDEN:  c_den = val;
            CFG_VOLTS: volts = val[9:0];
            CFG_TOL:   tol = val[11:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_status.size() > 0)
            @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic random_phase(int n);
        int k, st;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                pending_beats.push_back(edge_beat(1, $urandom_range(0, 3) == 0 ? $urandom
                                                  : $urandom_range(900, 1100)));
                pending_beats.push_back(edge_beat(0, $urandom_range(0, 1200)));
            end else begin
                st = $urandom_range(0, 9) < 8 ? $urandom_range(0, 2) : 3;
                pending_beats.push_back(poll_beat(st == 3 ? 12'($urandom) : reading_for(st),
                    $urandom_range(0, 5) == 0 ? 12'($urandom) : 12'($urandom_range(0, 3600)),
                    $urandom_range(0, 7) != 0));
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // directed: edges, duty extremes, no-change
        pending_beats.push_back(poll_beat(12'hFFF, 12'hFFF, 1));
        pending_beats.push_back(edge_beat(0, 5));
        pending_beats.push_back(edge_beat(1, 10));
        pending_beats.push_back(edge_beat(0, 0));
        pending_beats.push_back(poll_beat(3300, 0, 1));
        pending_beats.push_back(edge_beat(1, 1000));
        pending_beats.push_back(edge_beat(0, 1000));
        pending_beats.push_back(poll_beat(2800, 100, 1));
        pending_beats.push_back(edge_beat(1, 0));
        pending_beats.push_back(edge_beat(0, 600));
        pending_beats.push_back(edge_beat(1, 500));
        pending_beats.push_back(poll_beat(2000, 3600, 1));
        pending_beats.push_back(poll_beat(2000, 3600, 1));
        pending_beats.push_back(poll_beat(2000, 3600, 0));
        pending_beats.push_back(poll_beat(0, 0, 0));
        pending_beats.push_back(poll_beat(4095, 0, 0));
        pending_beats.push_back(edge_beat(1, 32'hFFFF_FFF0));
        pending_beats.push_back(edge_beat(0, 32'hFFFF_FFFF));
        pending_beats.push_back(poll_beat(2800, 0, 1));
        drain();
        // realistic pilot scaling: about 20.8 V at full scale, -12 V at zero reading
        write_reg(CFG_PNUM, 8); write_reg(CFG_PDEN, 1); write_reg(CFG_PBIAS, 12000);
        write_reg(CFG_CNUM, 65535); write_reg(CFG_CDEN, 1);
        write_reg(CFG_VOLTS, 1000); write_reg(CFG_TOL, 3000);
        random_phase(225);
        drain();
        write_reg(CFG_PNUM, 0); write_reg(CFG_PDEN, 0); write_reg(CFG_PBIAS, 65535);
        write_reg(CFG_CNUM, 1); write_reg(CFG_CDEN, 65535);
        write_reg(CFG_VOLTS, 1); write_reg(CFG_TOL, 0);
        random_phase(150);
        drain();
        write_reg(CFG_PNUM, 1); write_reg(CFG_PDEN, 1); write_reg(CFG_PBIAS, 0);
        write_reg(CFG_CNUM, 1); write_reg(CFG_CDEN, 0);
        write_reg(CFG_VOLTS, 240); write_reg(CFG_TOL, 500);
        random_phase(300);
        drain();
        write_reg(CFG_PNUM, 16'($urandom)); write_reg(CFG_PDEN, 16'($urandom_range(1, 65535)));
        write_reg(CFG_PBIAS, 16'($urandom)); write_reg(CFG_CNUM, 16'($urandom));
        write_reg(CFG_CDEN, 16'($urandom_range(1, 65535)));
        write_reg(CFG_VOLTS, 16'($urandom_range(1, 1000)));
        write_reg(CFG_TOL, 16'($urandom_range(0, 3000)));
        random_phase(225);
        drain();
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #6ms;
        $display("FAIL");
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/cpm_pkg.sv
hw/rtl/cpm_ctrl.sv
hw/rtl/cpm_datapath.sv
hw/rtl/charge_pilot_monitor.sv
hw/rtl/cpm_checker.sv
test/tb.sv
